### src/cle_pkg.sv
// cle_pkg: shared constants, codes and control types for the circular list engine
// no dependencies; used by the interfaces, the controller, the datapath and the top level

package cle_pkg;

  // store geometry (DEPTH is a power of two so the ring index wraps by truncation)
  localparam int DEPTH      = 64;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_WIDTH = 32;

  // transaction field widths
  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;

  // request modes; the remaining codes of the field are rejected
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_READ   = 3'd2,
    MODE_ROTATE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the incoming request
    logic read_pos;    // read the slot at the request position
    logic shift_init;  // start the shift counter
    logic shift_step;  // one shift read, advance counter
    logic commit;      // update list state and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_shift;  // insert or remove has entries to move
    logic last_step;   // current shift step is the final one
    logic out_free;    // result register can take a new result
  } status_t;

endpackage

### src/cle_in_if.sv
// cle_in_if, cle_out_if: request and result channels with valid/ready handshake
// depends on cle_pkg for field widths

interface cle_in_if;
  logic                             valid;
  logic                             ready;
  logic [cle_pkg::MODE_W-1:0]       mode;
  logic [cle_pkg::POS_W-1:0]        position;
  logic signed [cle_pkg::WORD_W-1:0] data_in;

  modport source (output valid, mode, position, data_in, input ready);
  modport sink   (input valid, mode, position, data_in, output ready);
endinterface

interface cle_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [cle_pkg::WORD_W-1:0] data_out;
  logic [cle_pkg::COUNT_W-1:0]       count;

  modport source (output valid, ok, data_out, count, input ready);
  modport sink   (input valid, ok, data_out, count, output ready);
endinterface

### src/cle_ctrl.sv
// cle_ctrl: state machine sequencing decode, entry shifting and result hand-off
// depends on cle_pkg for state, command and status types

module cle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cle_pkg::status_t  st,
  output cle_pkg::cmd_t     cmd
);
  import cle_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = st.need_shift ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        if (st.last_step) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.read_pos   = 1'b1;
        cmd.shift_init = st.need_shift;
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        cmd.commit = st.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/cle_datapath.sv
// cle_datapath: request registers, ring store, shift counter, list state and result register
// depends on cle_pkg; commanded by cle_ctrl

module cle_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cle_pkg::MODE_W-1:0]        in_mode,
  input  logic [cle_pkg::POS_W-1:0]         in_position,
  input  logic signed [cle_pkg::WORD_W-1:0] in_data_in,
  input  cle_pkg::cmd_t                     cmd,
  output cle_pkg::status_t                  st,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [cle_pkg::WORD_W-1:0] out_data_out,
  output logic [cle_pkg::COUNT_W-1:0]       out_count
);
  import cle_pkg::*;

  // ring store
  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // request and list state
  logic [MODE_W-1:0]     req_mode_r;
  logic [POS_W-1:0]      req_pos_r;
  logic [DATA_WIDTH-1:0] req_word_r;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]     first_r, first_nxt;

  // shift machinery
  logic [COUNT_W-1:0]    d_r;
  logic [COUNT_W-1:0]    src_idx;
  logic                  wpend_r;
  logic [ADDR_W-1:0]     wdst_r;
  logic [DATA_WIDTH-1:0] rd_q_r;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // result register
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [WORD_W-1:0]     out_data_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  legal;
  logic                  is_insert;
  logic                  is_remove;
  logic                  is_read;
  logic [ADDR_W-1:0]     pos_slot;

  // ring slot of a logical position
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] first,
                                               input logic [COUNT_W-1:0] logical);
    return first + logical[ADDR_W-1:0];
  endfunction

  assign is_insert = (req_mode_r == MODE_INSERT);
  assign is_remove = (req_mode_r == MODE_REMOVE);
  assign is_read   = (req_mode_r == MODE_READ);
  assign pos_slot  = slot_of(first_r, req_pos_r);

  // range check per mode
  always_comb begin
    case (req_mode_r) inside
      MODE_INSERT:
        legal = ({1'b0, req_pos_r} <= {1'b0, count_r}) && (count_r < COUNT_W'(DEPTH));
      MODE_REMOVE, MODE_READ, MODE_ROTATE:
        legal = ({1'b0, req_pos_r} < {1'b0, count_r});
      MODE_CLEAR:
        legal = 1'b1;
      default:
        legal = 1'b0;
    endcase
  end

  // status to the controller
  always_comb begin
    st.need_shift = legal &&
                    ((is_insert && (req_pos_r != count_r)) ||
                     (is_remove && (({1'b0, req_pos_r} + (COUNT_W+1)'(1)) !=
                                    {1'b0, count_r})));
    st.last_step  = is_insert ? ({1'b0, d_r} == ({1'b0, req_pos_r} + (COUNT_W+1)'(1)))
                              : (({1'b0, d_r} + (COUNT_W+1)'(2)) == {1'b0, count_r});
    st.out_free   = !out_valid_r || out_ready;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_pos_r  <= in_position;
      req_word_r <= DATA_WIDTH'(in_data_in);
    end
  end

  // shift source: insert moves entries up, remove moves them down
  assign src_idx = is_insert ? (d_r - COUNT_W'(1)) : (d_r + COUNT_W'(1));

  // read port select
  always_comb begin
    rd_en   = cmd.read_pos || cmd.shift_step;
    rd_addr = cmd.shift_step ? slot_of(first_r, src_idx) : pos_slot;
  end

  // write port select: pending shift write or the inserted word at commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wdst_r;
    wr_data = rd_q_r;
    if (wpend_r) begin
      wr_en = 1'b1;
    end else if (cmd.commit && is_insert && legal) begin
      wr_en   = 1'b1;
      wr_addr = pos_slot;
      wr_data = req_word_r;
    end
  end

  // store access
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  // shift counter and pending write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpend_r <= 1'b0;
    end else begin
      wpend_r <= cmd.shift_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_init) begin
      d_r <= is_insert ? count_r : COUNT_W'(req_pos_r);
    end else if (cmd.shift_step) begin
      d_r <= is_insert ? (d_r - COUNT_W'(1)) : (d_r + COUNT_W'(1));
    end
    if (cmd.shift_step) wdst_r <= slot_of(first_r, d_r);
  end

  // list state after the request
  always_comb begin
    count_nxt = count_r;
    first_nxt = first_r;
    if (legal) begin
      case (req_mode_r)
        MODE_INSERT: count_nxt = count_r + COUNT_W'(1);
        MODE_REMOVE: count_nxt = count_r - COUNT_W'(1);
        MODE_ROTATE: first_nxt = pos_slot;
        MODE_CLEAR: begin
          count_nxt = '0;
          first_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      first_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      first_r <= first_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok_r    <= legal;
      out_data_r  <= (legal && is_read) ? WORD_W'(rd_q_r) : '0;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_data_out = out_data_r;
  assign out_count    = out_count_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(DEPTH))
    else $error("list count above store depth");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wpend_r && cmd.commit))
    else $error("shift write collides with commit");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_insert && legal) |=> (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("accepted insert did not grow the list");

endmodule

### src/circular_list_engine.sv
// circular_list_engine: top level of the bounded circular ordered list
// depends on cle_pkg, cle_in_if/cle_out_if, cle_ctrl and cle_datapath
//
// Usage
//   in_if  : request transactions (mode, position, data_in), valid/ready.
//   out_if : one result transaction per request (ok, data_out, count).
//   Requests are served one at a time. A request is taken in the idle state,
//   decoded in the next cycle, then insert and remove move the entries behind
//   the position one per cycle through the single-port-pair ring store
//   (read one slot, write the neighbour in the following cycle, overlapped).
//   Read, rotate, clear, rejected requests and shift-free inserts/removes go
//   from decode straight to the result; otherwise n entries move, n being
//   count - position for insert and count - position - 1 for remove, which
//   is at most 63 entries at a depth of 64. The next request is taken only
//   in the idle state after the result is registered, so a request is never
//   taken before the one ahead of it has been committed.
//   A result sits in an output register until taken; a new request is still
//   accepted meanwhile, and its commit waits while the previous result is
//   stalled by out_if.ready low. Nothing is lost or repeated under back-pressure.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; store contents are undefined until written and need no clearing.

module circular_list_engine (
  input  logic       clk,
  input  logic       rst_n,
  cle_in_if.sink     in_if,
  cle_out_if.source  out_if
);
  import cle_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencing
  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // store and list state
  cle_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_if.mode),
    .in_position  (in_if.position),
    .in_data_in   (in_if.data_in),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_if.ready),
    .out_valid    (out_if.valid),
    .out_ok       (out_if.ok),
    .out_data_out (out_if.data_out),
    .out_count    (out_if.count)
  );

endmodule
